// ===== design/jos_pkg.sv =====
// Shared constants and types for the Josephus elimination block.
// No dependencies; imported by the controller and the top level.
package jos_pkg;

	localparam int MAX_PEOPLE_DEF = 64;
	localparam int VALUE_W        = 32;
	localparam int STEP_W         = 10;
	localparam int PDATA_W        = 32;
	localparam int PADDR_W        = 3;

	localparam logic [STEP_W-1:0] STEP_RESET = 10'd2;

	// register index, taken from paddr[2]
	localparam logic REG_STEP = 1'b0;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CLOSE,
		ST_ISSUE,
		ST_USE
	} jos_state_t;

endpackage

// ===== design/josephus_elimination_order.sv =====
// Top level of the Josephus elimination block: configuration register,
// sequencer and the value and link RAMs. Depends on jos_pkg, jos_ctrl, jos_ram.
//
//   channel   direction  handshake           payload
//   request   in         req_valid/req_stall person_value, last_person
//   result    out        rsp_valid/rsp_stall out_value, is_survivor, overflowed
//   config    in         APB psel/penable    paddr, pwdata, prdata (step_count)
//
// Loading accepts one person per cycle. A run then closes the ring and follows
// each link and gives each result through the ISSUE and USE states in turn, as
// the link RAM has registered read data and each read depends on the last. No
// requests are taken during a run. Reset clears the loaded count and overflow
// flag; the RAMs need no clearing. A stalled result holds the sequencer only
// when the next result is ready.
module josephus_elimination_order #(
	parameter int MAX_PEOPLE = jos_pkg::MAX_PEOPLE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [jos_pkg::PADDR_W-1:0]         paddr,
	input  logic [jos_pkg::PDATA_W-1:0]         pwdata,
	output logic [jos_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic signed [jos_pkg::VALUE_W-1:0]  person_value,
	input  logic                                last_person,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic signed [jos_pkg::VALUE_W-1:0]  out_value,
	output logic                                is_survivor,
	output logic                                overflowed
);

	import jos_pkg::*;

	localparam int AW = $clog2(MAX_PEOPLE);

	logic [STEP_W-1:0]  step_q;
	logic               cfg_wr;
	logic               val_we;
	logic               link_we;
	logic [AW-1:0]      waddr;
	logic [VALUE_W-1:0] val_wdata;
	logic [AW-1:0]      link_wdata;
	logic               mem_re;
	logic [AW-1:0]      raddr;
	logic [VALUE_W-1:0] val_rdata;
	logic [AW-1:0]      link_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_wr) begin
			step_q <= pwdata[STEP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_STEP) ? PDATA_W'(step_q) : '0;

	jos_ctrl #(
		.MAX_PEOPLE(MAX_PEOPLE)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_count  (step_q),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.person_value(person_value),
		.last_person (last_person),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.out_value   (out_value),
		.is_survivor (is_survivor),
		.overflowed  (overflowed),
		.val_we      (val_we),
		.link_we     (link_we),
		.waddr       (waddr),
		.val_wdata   (val_wdata),
		.link_wdata  (link_wdata),
		.mem_re      (mem_re),
		.raddr       (raddr),
		.val_rdata   (val_rdata),
		.link_rdata  (link_rdata)
	);

	jos_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_PEOPLE)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(waddr),
		.wdata(val_wdata),
		.re   (mem_re),
		.raddr(raddr),
		.rdata(val_rdata)
	);

	jos_ram #(
		.WIDTH(AW),
		.DEPTH(MAX_PEOPLE)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(waddr),
		.wdata(link_wdata),
		.re   (mem_re),
		.raddr(raddr),
		.rdata(link_rdata)
	);

endmodule

// ===== design/jos_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No dependencies.
module jos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/jos_ctrl.sv =====
// Load and elimination sequencer: appends people, then walks the link RAM
// and removes every step-th person. Depends on jos_pkg; drives two jos_ram.
module jos_ctrl #(
	parameter int MAX_PEOPLE = jos_pkg::MAX_PEOPLE_DEF,
	parameter int AW         = $clog2(MAX_PEOPLE),
	parameter int CNT_W      = $clog2(MAX_PEOPLE + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [jos_pkg::STEP_W-1:0]          step_count,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic signed [jos_pkg::VALUE_W-1:0]  person_value,
	input  logic                                last_person,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic signed [jos_pkg::VALUE_W-1:0]  out_value,
	output logic                                is_survivor,
	output logic                                overflowed,
	output logic                                val_we,
	output logic                                link_we,
	output logic [AW-1:0]                       waddr,
	output logic [jos_pkg::VALUE_W-1:0]         val_wdata,
	output logic [AW-1:0]                       link_wdata,
	output logic                                mem_re,
	output logic [AW-1:0]                       raddr,
	input  logic [jos_pkg::VALUE_W-1:0]         val_rdata,
	input  logic [AW-1:0]                       link_rdata
);

	import jos_pkg::*;

	jos_state_t          state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                ovf_q, ovf_d;
	logic [AW-1:0]       curr_q, curr_d;
	logic [AW-1:0]       prev_q, prev_d;
	logic [CNT_W-1:0]    remain_q, remain_d;
	logic [STEP_W-1:0]   hops_q, hops_d;
	logic                out_valid_q, out_valid_d;
	logic [VALUE_W-1:0]  out_value_q, out_value_d;
	logic                out_surv_q, out_surv_d;
	logic                out_ovf_q, out_ovf_d;
	logic                req_acc;
	logic                full;
	logic                slot_free;
	logic [STEP_W-1:0]   hops_init;

	assign req_stall = (state_q != ST_LOAD);
	assign req_acc   = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(MAX_PEOPLE));
	assign slot_free = !out_valid_q || !rsp_stall;
	// a step of zero acts as a step of one
	assign hops_init = (step_count == '0) ? '0 : step_count - 1'b1;

	assign rsp_valid   = out_valid_q;
	assign out_value   = $signed(out_value_q);
	assign is_survivor = out_surv_q;
	assign overflowed  = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			ovf_q       <= ovf_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		curr_q      <= curr_d;
		prev_q      <= prev_d;
		remain_q    <= remain_d;
		hops_q      <= hops_d;
		out_value_q <= out_value_d;
		out_surv_q  <= out_surv_d;
		out_ovf_q   <= out_ovf_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		ovf_d       = ovf_q;
		curr_d      = curr_q;
		prev_d      = prev_q;
		remain_d    = remain_q;
		hops_d      = hops_q;
		out_valid_d = out_valid_q && rsp_stall;
		out_value_d = out_value_q;
		out_surv_d  = out_surv_q;
		out_ovf_d   = out_ovf_q;
		val_we      = 1'b0;
		link_we     = 1'b0;
		waddr       = count_q[AW-1:0];
		val_wdata   = person_value;
		link_wdata  = AW'(count_q + 1'b1);
		mem_re      = 1'b0;
		raddr       = curr_q;

		case (state_q)
			ST_LOAD: begin
				if (req_acc) begin
					if (!full) begin
						val_we  = 1'b1;
						link_we = 1'b1;
						count_d = CNT_W'(count_q + 1'b1);
					end else begin
						ovf_d = 1'b1;
					end
					if (last_person) begin
						state_d = ST_CLOSE;
					end
				end
			end
			ST_CLOSE: begin
				// close the ring: last loaded person points back to the first
				link_we    = 1'b1;
				waddr      = AW'(count_q - 1'b1);
				link_wdata = '0;
				curr_d     = '0;
				prev_d     = AW'(count_q - 1'b1);
				remain_d   = count_q;
				hops_d     = (count_q == CNT_W'(1)) ? '0 : hops_init;
				state_d    = ST_ISSUE;
			end
			ST_ISSUE: begin
				mem_re  = 1'b1;
				state_d = ST_USE;
			end
			ST_USE: begin
				if (hops_q != '0) begin
					prev_d  = curr_q;
					curr_d  = link_rdata;
					hops_d  = hops_q - 1'b1;
					state_d = ST_ISSUE;
				end else if (slot_free) begin
					out_valid_d = 1'b1;
					out_value_d = val_rdata;
					out_surv_d  = (remain_q == CNT_W'(1));
					out_ovf_d   = ovf_q;
					if (remain_q == CNT_W'(1)) begin
						count_d = '0;
						ovf_d   = 1'b0;
						state_d = ST_LOAD;
					end else begin
						// unlink the removed person; written before the next read is issued
						link_we    = 1'b1;
						waddr      = prev_q;
						link_wdata = link_rdata;
						curr_d     = link_rdata;
						remain_d   = remain_q - 1'b1;
						hops_d     = (remain_q == CNT_W'(2)) ? '0 : hops_init;
						state_d    = ST_ISSUE;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PEOPLE))
		else $error("loaded count beyond storage depth");

	a_run_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE || state_q == ST_USE) |-> remain_q != '0 && remain_q <= count_q)
		else $error("remaining count out of range during run");

	a_curr_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE || state_q == ST_USE) |-> CNT_W'(curr_q) < count_q)
		else $error("walk left the loaded entries");

	a_survivor_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_USE && hops_q == '0 && slot_free && remain_q == CNT_W'(1))
		|=> state_q == ST_LOAD && count_q == '0 && !ovf_q && out_valid_q && out_surv_q)
		else $error("survivor result did not end the run");

endmodule
